// File: src/wait_throttle_watchdog_core_defines.svh
// Assertion macros shared by the throttle watchdog checker.
// Depends on nothing; the including scope supplies clk and rst.
`ifndef WAIT_THROTTLE_WATCHDOG_CORE_DEFINES_SVH
`define WAIT_THROTTLE_WATCHDOG_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define WTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define WTW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/wtw_pkg.sv
// Types, codes and helpers for the wait throttle watchdog.
// Used by wtw_update, wait_throttle_watchdog_core and wtw_checker.
`default_nettype none

package wtw_pkg;

  localparam int COUNT_WIDTH = 32;

  localparam int TDATA_IN_W  = 40;
  localparam int TDATA_OUT_W = 280;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    CMD_ARM    = 2'd0,
    CMD_WAIT   = 2'd1,
    CMD_BYPASS = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_SLOT    = 2'd0,
    OUT_TIMEOUT = 2'd1,
    OUT_FAILED  = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    REF_NONE         = 3'd0,
    REF_DISABLED     = 3'd1,
    REF_NO_CHAIN     = 3'd2,
    REF_NOT_WAITABLE = 3'd3,
    REF_NO_HANDLE    = 3'd4,
    REF_GAVE_UP      = 3'd5
  } refusal_t;

  // register indexes on the configuration port
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  outcome;
    logic [31:0] blocked;
    logic        chain;
    logic        waitable;
    logic        handle;
  } wtw_item_t;

  typedef struct packed {
    logic        armed;
    refusal_t    refusal;
    count_t      wait_cnt;
    count_t      slot_cnt;
    count_t      timeout_cnt;
    count_t      failure_cnt;
    count_t      bypass_cnt;
    logic [15:0] run;
    logic [63:0] blocked_sum;
    logic [31:0] blocked_peak;
  } wtw_state_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // report a counter as 32 bits: truncate or zero extend
  function automatic logic [31:0] cnt_out(input count_t v);
    logic [63:0] ext;
    ext = 64'(v);
    return ext[31:0];
  endfunction

endpackage

`default_nettype wire

// File: src/wait_throttle_watchdog_core.sv
// Wait throttle watchdog: arming verdict and wait statistics, one event per cycle
// while the output is not stalled. Depends on wtw_pkg and wtw_update.
//
// Events enter on the s_axis channel (kind in tuser) and every event yields one
// status transaction on m_axis. The status is computed combinationally from the
// accepted event and the current state and lands in the output register at the
// same edge that updates the state, and m_axis_tvalid is set with it. Throughput
// is one event per cycle while m_axis is not stalled; the state update through
// wtw_update (one 64-bit saturating add and a few counter increments) sets it.
// s_axis_tready stays high while the output register is empty or being taken,
// so a stalled receiver holds the pending status and blocks only further input.
// Configuration sits on an APB port: enable at address 0 (bit 0, reset 1),
// give_up_limit at address 4 (bits 15:0, reset 0). Write it only while idle.
// Synchronous reset clears every counter, disarms, sets refusal to none and
// empties the output register.
`default_nettype none

module wait_throttle_watchdog_core
  import wtw_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready,
  // events
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // outcome[1:0], blocked_time_ns[33:2], has_extended_chain[34],
  // waitable_present[35], handle_present[36], zero fill[39:37]
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  wire logic [1:0]             s_axis_tuser,
  // status
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // transition[0], wait_allowed[1], armed_now[2], refusal_code[5:3],
  // wait_total[37:6], slot_total[69:38], timeout_total[101:70],
  // failure_total[133:102], bypass_total[165:134], timeout_run[181:166],
  // blocked_sum_ns[245:182], blocked_peak_ns[277:246], zero fill[279:278]
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata
);

  logic        enable;
  logic [15:0] limit;
  wtw_state_t  state;
  wtw_state_t  state_next;
  wtw_item_t   item;
  logic        transition;
  logic        wait_allowed;
  logic        in_fire;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_LIMIT) ? {16'd0, limit} : {31'd0, enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
      limit  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ENABLE) begin
        enable <= pwdata[0];
      end else begin
        limit <= pwdata[15:0];
      end
    end
  end

  assign item.cmd      = s_axis_tuser;
  assign item.outcome  = s_axis_tdata[1:0];
  assign item.blocked  = s_axis_tdata[33:2];
  assign item.chain    = s_axis_tdata[34];
  assign item.waitable = s_axis_tdata[35];
  assign item.handle   = s_axis_tdata[36];

  wtw_update u_update (
    .cur        (state),
    .item       (item),
    .enable     (enable),
    .limit      (limit),
    .nxt        (state_next),
    .transition (transition)
  );

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign wait_allowed  = enable && state_next.armed && (state_next.refusal == REF_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{
        armed:        1'b0,
        refusal:      REF_NONE,
        wait_cnt:     '0,
        slot_cnt:     '0,
        timeout_cnt:  '0,
        failure_cnt:  '0,
        bypass_cnt:   '0,
        run:          '0,
        blocked_sum:  '0,
        blocked_peak: '0
      };
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // payload register: load on each accepted event, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {
        2'd0,
        state_next.blocked_peak,
        state_next.blocked_sum,
        state_next.run,
        cnt_out(state_next.bypass_cnt),
        cnt_out(state_next.failure_cnt),
        cnt_out(state_next.timeout_cnt),
        cnt_out(state_next.slot_cnt),
        cnt_out(state_next.wait_cnt),
        3'(state_next.refusal),
        state_next.armed,
        wait_allowed,
        transition
      };
    end
  end

endmodule

`default_nettype wire

// File: src/wtw_update.sv
// Next-state logic of the throttle watchdog for one event.
// Depends on wtw_pkg.
`default_nettype none

module wtw_update
  import wtw_pkg::*;
(
  input  wire wtw_state_t  cur,
  input  wire wtw_item_t   item,
  input  wire logic        enable,
  input  wire logic [15:0] limit,
  output wtw_state_t       nxt,
  output logic             transition
);

  logic [64:0] sum_wide;
  logic [15:0] run_inc;

  assign sum_wide = {1'b0, cur.blocked_sum} + 65'(item.blocked);
  assign run_inc  = (cur.run == 16'hFFFF) ? cur.run : cur.run + 16'd1;

  always_comb begin
    nxt        = cur;
    transition = 1'b0;
    unique case (item.cmd)
      CMD_ARM: begin
        priority if (!enable) begin
          nxt.refusal = REF_DISABLED;
        end else if (!item.chain) begin
          nxt.refusal = REF_NO_CHAIN;
        end else if (!item.waitable) begin
          nxt.refusal = REF_NOT_WAITABLE;
        end else if (!item.handle) begin
          nxt.refusal = REF_NO_HANDLE;
        end else begin
          nxt.refusal = REF_NONE;
        end
        nxt.armed = (nxt.refusal == REF_NONE);
      end
      CMD_WAIT: begin
        nxt.wait_cnt    = sat_inc(cur.wait_cnt);
        nxt.blocked_sum = sum_wide[64] ? '1 : sum_wide[63:0];
        if (item.blocked > cur.blocked_peak) begin
          nxt.blocked_peak = item.blocked;
        end
        unique case (item.outcome)
          OUT_SLOT: begin
            nxt.slot_cnt = sat_inc(cur.slot_cnt);
            nxt.run      = '0;
          end
          OUT_FAILED: begin
            nxt.failure_cnt = sat_inc(cur.failure_cnt);
            nxt.armed       = 1'b0;
            nxt.refusal     = REF_GAVE_UP;
            transition      = cur.armed;
          end
          default: begin
            // timeout, and the unused outcome code acts the same
            nxt.timeout_cnt = sat_inc(cur.timeout_cnt);
            nxt.run         = run_inc;
            if (limit != 16'd0 && run_inc >= limit) begin
              nxt.armed   = 1'b0;
              nxt.refusal = REF_GAVE_UP;
              transition  = cur.armed;
            end
          end
        endcase
      end
      CMD_BYPASS: begin
        nxt.bypass_cnt = sat_inc(cur.bypass_cnt);
      end
      default: begin
        // unused command: hold state, report status only
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/wtw_checker.sv
// Port-level checks for wait_throttle_watchdog_core, bound to the top level.
// Depends on wtw_pkg and wait_throttle_watchdog_core_defines.svh.
`default_nettype none

`include "wait_throttle_watchdog_core_defines.svh"

module wtw_checker
  import wtw_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [TDATA_OUT_W-1:0] m_axis_tdata
);

  logic shows_transition;
  logic shows_gave_up;
  logic shows_allowed;
  logic shows_armed_none;
  logic out_stall;

  assign shows_transition = m_axis_tvalid && m_axis_tdata[0];
  assign shows_gave_up    = !m_axis_tdata[2] && (m_axis_tdata[5:3] == REF_GAVE_UP);
  assign shows_allowed    = m_axis_tvalid && m_axis_tdata[1];
  assign shows_armed_none = m_axis_tdata[2] && (m_axis_tdata[5:3] == REF_NONE);
  assign out_stall        = m_axis_tvalid && !m_axis_tready;

  `WTW_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid after reset")

  `WTW_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled while empty")

  `WTW_ASSERT(a_transition_disarms, shows_transition |-> shows_gave_up, "transition kept armed")

  `WTW_ASSERT(a_allowed_armed, shows_allowed |-> shows_armed_none, "wait allowed while not armed")

  `WTW_ASSERT(a_stall_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stall not held")

endmodule

bind wait_throttle_watchdog_core wtw_checker u_wtw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: dv/tb_wait_throttle_watchdog_core.sv
// Testbench for wait_throttle_watchdog_core: arm, wait and bypass events go in on the
// event stream, each status transaction is checked field by field against an in-bench model.
// Depends on wtw_pkg and the core RTL.

module tb_wait_throttle_watchdog_core;
  import wtw_pkg::*;

  localparam int         CLK_HALF    = 5;
  localparam int         QUIET_LIMIT = 5000;
  localparam logic [2:0] ADDR_ENABLE = {REG_ENABLE, 2'b00};
  localparam logic [2:0] ADDR_LIMIT  = {REG_LIMIT, 2'b00};
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] OUT_UNUSED  = 2'd3;
  localparam int         RUN_LEN     = 60;

  typedef struct {
    bit          transition;
    bit          allowed;
    bit          armed;
    refusal_t    refusal;
    bit [31:0]   waits;
    bit [31:0]   slots;
    bit [31:0]   timeouts;
    bit [31:0]   failures;
    bit [31:0]   bypasses;
    bit [15:0]   run;
    bit [63:0]   blocked_sum;
    bit [31:0]   blocked_peak;
  } status_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [2:0]             paddr         = '0;
  logic [31:0]            pwdata        = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // outcome[1:0], blocked_time_ns[33:2], has_extended_chain[34],
  // waitable_present[35], handle_present[36], zero fill[39:37]
  logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
  // cmd[1:0]
  logic [1:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  // transition[0], wait_allowed[1], armed_now[2], refusal_code[5:3],
  // wait_total[37:6], slot_total[69:38], timeout_total[101:70],
  // failure_total[133:102], bypass_total[165:134], timeout_run[181:166],
  // blocked_sum_ns[245:182], blocked_peak_ns[277:246], zero fill[279:278]
  logic [TDATA_OUT_W-1:0] m_axis_tdata;

  // throttle model: configuration and state
  bit        cfg_enable = 1'b1;
  bit [15:0] cfg_limit  = '0;
  bit        thr_armed  = 1'b0;
  refusal_t  thr_refusal = REF_NONE;
  bit [31:0] thr_waits, thr_slots, thr_timeouts, thr_failures, thr_bypasses;
  bit [15:0] thr_run;
  bit [63:0] thr_sum;
  bit [31:0] thr_peak;

  status_t pending_status[$];
  int      gap_pct         = 0;
  int      stall_pct       = 0;
  int      mismatches      = 0;
  int      events_sent     = 0;
  int      results_checked = 0;
  int      quiet_cycles    = 0;

  wait_throttle_watchdog_core uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  function automatic bit [31:0] count_up(input bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // disarm with gave-up; report whether the throttle was armed
  function automatic bit give_up();
    bit was;
    was         = thr_armed;
    thr_armed   = 1'b0;
    thr_refusal = REF_GAVE_UP;
    return was;
  endfunction

  function automatic status_t throttle_predict(input logic [1:0] cmd, input logic [1:0] outcome,
                                               input logic [31:0] blocked, input logic chain,
                                               input logic waitable, input logic handle);
    status_t    s;
    bit [64:0]  total;
    s.transition = 1'b0;
    case (cmd)
      CMD_ARM: begin
        if (!cfg_enable)   thr_refusal = REF_DISABLED;
        else if (!chain)    thr_refusal = REF_NO_CHAIN;
        else if (!waitable) thr_refusal = REF_NOT_WAITABLE;
        else if (!handle)   thr_refusal = REF_NO_HANDLE;
        else                thr_refusal = REF_NONE;
        thr_armed = (thr_refusal == REF_NONE);
      end
      CMD_WAIT: begin
        thr_waits = count_up(thr_waits);
        total     = {1'b0, thr_sum} + {33'd0, blocked};
        thr_sum   = total[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total[63:0];
        if (blocked > thr_peak) thr_peak = blocked;
        case (outcome)
          OUT_SLOT: begin
            thr_slots = count_up(thr_slots);
            thr_run   = '0;
          end
          OUT_FAILED: begin
            thr_failures = count_up(thr_failures);
            s.transition = give_up();
          end
          default: begin
            // unused outcome counts as a timeout
            thr_timeouts = count_up(thr_timeouts);
            if (thr_run != 16'hFFFF) thr_run = thr_run + 16'd1;
            if (cfg_limit != 0 && thr_run >= cfg_limit) s.transition = give_up();
          end
        endcase
      end
      CMD_BYPASS: thr_bypasses = count_up(thr_bypasses);
      default: ;
    endcase
    s.allowed      = cfg_enable && thr_armed && (thr_refusal == REF_NONE);
    s.armed        = thr_armed;
    s.refusal      = thr_refusal;
    s.waits        = thr_waits;
    s.slots        = thr_slots;
    s.timeouts     = thr_timeouts;
    s.failures     = thr_failures;
    s.bypasses     = thr_bypasses;
    s.run          = thr_run;
    s.blocked_sum  = thr_sum;
    s.blocked_peak = thr_peak;
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_status(input status_t want, input logic [TDATA_OUT_W-1:0] d);
    check_field("transition", want.transition, d[0]);
    check_field("wait_allowed", want.allowed, d[1]);
    check_field("armed_now", want.armed, d[2]);
    check_field("refusal_code", want.refusal, d[5:3]);
    check_field("wait_total", want.waits, d[37:6]);
    check_field("slot_total", want.slots, d[69:38]);
    check_field("timeout_total", want.timeouts, d[101:70]);
    check_field("failure_total", want.failures, d[133:102]);
    check_field("bypass_total", want.bypasses, d[165:134]);
    check_field("timeout_run", want.run, d[181:166]);
    check_field("blocked_sum_ns", want.blocked_sum, d[245:182]);
    check_field("blocked_peak_ns", want.blocked_peak, d[277:246]);
  endfunction

  // predict on each accepted event, compare each accepted status
  always @(posedge clk) begin : status_monitor
    status_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_status.size() == 0) begin
          $display("%0t: status transaction with nothing expected, actual %0h",
                   $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_status.pop_front();
          check_status(want, m_axis_tdata);
        end
        results_checked++;
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_status.push_back(throttle_predict(s_axis_tuser, s_axis_tdata[1:0],
                                                  s_axis_tdata[33:2], s_axis_tdata[34],
                                                  s_axis_tdata[35], s_axis_tdata[36]));
    end
  end

  always @(negedge clk)
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d status transactions outstanding",
               $time, quiet_cycles, pending_status.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input logic [1:0] cmd, input logic [1:0] outcome,
                            input logic [31:0] blocked, input logic chain,
                            input logic waitable, input logic handle);
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, handle, waitable, chain, blocked, outcome};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    events_sent++;
  endtask

  // drop valid and hold until every status has come back
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ENABLE) cfg_enable = data[0];
    else                     cfg_limit  = data[15:0];
    @(negedge clk);
    // read back the register just written
    check_field("prdata", (addr == ADDR_ENABLE) ? {31'd0, data[0]} : {16'd0, data[15:0]},
                prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_random();
    logic [1:0]  cmd;
    logic [1:0]  outcome;
    logic [31:0] blocked;
    logic [2:0]  flags;
    int          pick;
    pick = $urandom_range(0, 99);
    cmd  = (pick < 15) ? CMD_ARM : (pick < 80) ? CMD_WAIT : (pick < 95) ? CMD_BYPASS
                                                                          : CMD_UNUSED;
    pick    = $urandom_range(0, 99);
    outcome = (pick < 50) ? OUT_SLOT : (pick < 80) ? OUT_TIMEOUT : (pick < 92) ? OUT_FAILED
                                                                               : OUT_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 10)      blocked = '0;
    else if (pick < 15) blocked = '1;
    else if (pick < 60) blocked = $urandom_range(0, 20000);
    else                blocked = $urandom;
    // mostly a fully ready chain so that arming succeeds
    flags = ($urandom_range(0, 99) < 70) ? 3'b111 : 3'($urandom_range(0, 7));
    send_event(cmd, outcome, blocked, flags[0], flags[1], flags[2]);
  endtask

  task automatic test_arm_priority();
    send_event(CMD_ARM, OUT_SLOT, 32'd0, 1'b0, 1'b1, 1'b1);
    send_event(CMD_ARM, OUT_FAILED, 32'd0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_ARM, OUT_SLOT, 32'd0, 1'b1, 1'b0, 1'b1);
    send_event(CMD_ARM, OUT_SLOT, 32'd0, 1'b1, 1'b1, 1'b0);
    send_event(CMD_ARM, OUT_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_wait_outcomes();
    send_event(CMD_WAIT, OUT_SLOT, 32'd0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_WAIT, OUT_TIMEOUT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_event(CMD_WAIT, OUT_UNUSED, 32'd12345, 1'b0, 1'b1, 1'b0);
    send_event(CMD_WAIT, OUT_SLOT, 32'd7, 1'b1, 1'b0, 1'b1);
    send_event(CMD_BYPASS, OUT_FAILED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_event(CMD_UNUSED, OUT_FAILED, 32'h8000_0000, 1'b1, 1'b1, 1'b1);
    // failure while armed disarms, a second failure finds it disarmed
    send_event(CMD_WAIT, OUT_FAILED, 32'd1, 1'b0, 1'b0, 1'b0);
    send_event(CMD_WAIT, OUT_FAILED, 32'd0, 1'b0, 1'b0, 1'b0);
    send_event(CMD_BYPASS, OUT_SLOT, 32'd0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_give_up_limit();
    drain_results();
    write_reg(ADDR_LIMIT, 32'd2);
    send_event(CMD_ARM, OUT_SLOT, 32'd0, 1'b1, 1'b1, 1'b1);
    send_event(CMD_WAIT, OUT_TIMEOUT, 32'd100, 1'b1, 1'b1, 1'b1);
    send_event(CMD_WAIT, OUT_TIMEOUT, 32'd200, 1'b1, 1'b1, 1'b1);
    // re-arm keeps the timeout run, so the next timeout gives up at once
    send_event(CMD_ARM, OUT_SLOT, 32'd0, 1'b1, 1'b1, 1'b1);
    send_event(CMD_WAIT, OUT_UNUSED, 32'd300, 1'b1, 1'b1, 1'b1);
    send_event(CMD_ARM, OUT_SLOT, 32'd0, 1'b1, 1'b1, 1'b1);
    send_event(CMD_WAIT, OUT_SLOT, 32'd50, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_disabled();
    drain_results();
    write_reg(ADDR_ENABLE, 32'd0);
    // still armed from before, but waiting is not allowed
    send_event(CMD_BYPASS, OUT_SLOT, 32'd0, 1'b1, 1'b1, 1'b1);
    send_event(CMD_ARM, OUT_SLOT, 32'd0, 1'b1, 1'b1, 1'b1);
    send_event(CMD_WAIT, OUT_SLOT, 32'd9, 1'b1, 1'b1, 1'b1);
    drain_results();
    write_reg(ADDR_ENABLE, 32'hFFFF_FFFF);
    write_reg(ADDR_LIMIT, 32'd0);
  endtask

  // build a long timeout run, hold it under the largest limit, then give up below it
  task automatic test_long_run();
    send_event(CMD_ARM, OUT_SLOT, 32'd0, 1'b1, 1'b1, 1'b1);
    repeat (RUN_LEN) send_event(CMD_WAIT, OUT_TIMEOUT, $urandom_range(0, 65535),
                                1'b1, 1'b1, 1'b1);
    drain_results();
    write_reg(ADDR_LIMIT, 32'h0001_FFFF);
    send_event(CMD_WAIT, OUT_UNUSED, 32'd0, 1'b1, 1'b1, 1'b1);
    drain_results();
    write_reg(ADDR_LIMIT, 32'd40);
    send_event(CMD_WAIT, OUT_TIMEOUT, 32'd5, 1'b1, 1'b1, 1'b1);
    send_event(CMD_WAIT, OUT_SLOT, 32'd0, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic(input int gap, input int stall, input bit en,
                                     input int limit, input int count, input int pause_at);
    drain_results();
    write_reg(ADDR_ENABLE, {31'd0, en});
    write_reg(ADDR_LIMIT, limit);
    gap_pct   = gap;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain_results();
      send_random();
    end
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_arm_priority();
    test_wait_outcomes();
    test_give_up_limit();
    test_disabled();
    test_long_run();
    test_random_traffic(0, 0, 1'b1, 0, 300, -1);
    test_random_traffic(49, 0, 1'b1, 3, 300, 150);
    test_random_traffic(0, 49, 1'b1, 1, 300, -1);
    test_random_traffic(28, 28, 1'b1, $urandom_range(2, 8), 300, -1);
    test_random_traffic(28, 28, 1'b0, 65535, 300, -1);
    drain_results();
    repeat (5) @(posedge clk);
    $display("Covered arm verdicts, all wait outcomes, give-up limits 0..65535, enable off/on,");
    $display("long timeout runs: %0d events sent, %0d status transactions checked, %0d mismatches",
             events_sent, results_checked, mismatches);
    if (mismatches == 0 && pending_status.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/wtw_pkg.sv
src/wtw_update.sv
src/wait_throttle_watchdog_core.sv
src/wtw_checker.sv
dv/tb_wait_throttle_watchdog_core.sv
